// ===== sv/ctw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the text console character writer.
// No dependencies; ctw_if and text_console_char_writer take names from here by scope.
package ctw_pkg;

    // Payload field widths
    localparam int MODE_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int OFFSET_W = 11;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = 16;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CODE_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CODE_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CODE_PRINT_HI = 8'h7F;
    localparam logic [CHAR_W-1:0] BLANK_CHAR    = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
    localparam logic [CELL_W-1:0] CELL_RESET  = 16'h0F20;

endpackage

// ===== sv/ctw_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the console command and result words.
// Depends on ctw_pkg for the field widths.
interface ctw_in_if;
    logic                        valid;
    logic                        ready;
    logic [ctw_pkg::MODE_W-1:0]  mode;
    logic [ctw_pkg::CHAR_W-1:0]  char_code;
    logic [ctw_pkg::RROW_W-1:0]  read_row;
    logic [ctw_pkg::RCOL_W-1:0]  read_col;

    modport source (output valid, mode, char_code, read_row, read_col, input ready);
    modport sink   (input valid, mode, char_code, read_row, read_col, output ready);
endinterface

interface ctw_out_if;
    logic                          valid;
    logic                          ready;
    logic [ctw_pkg::OFFSET_W-1:0]  cursor_offset;
    logic [ctw_pkg::CELL_W-1:0]    cell_word;

    modport source (output valid, cursor_offset, cell_word, input ready);
    modport sink   (input valid, cursor_offset, cell_word, output ready);
endinterface

// ===== sv/ctw_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ctw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/text_console_char_writer.sv =====
`timescale 1ns / 1ps
// Text console over a ROWS x COLUMNS cell memory (char low byte, attribute high byte).
// After reset the block writes blanks into every cell of the cell memory before it
// takes its first word. A put or unused-mode word then passes through S_EXEC and
// S_DONE to its result; an in-range read also passes S_RDWAIT for the registered
// memory read. Rows are addressed through a circular top-row pointer, so a scroll
// only blanks one physical row. A clear blanks every cell. Both sweeps are paced by
// the single write port of the cell memory. A result waits in an output register
// and the next word is accepted while it waits.
// Depends on ctw_pkg, ctw_if (ctw_in_if, ctw_out_if) and ctw_ram.
module text_console_char_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [ctw_pkg::ATTR_W-1:0] cfg_wr_data,
    ctw_in_if.sink                     in_ch,
    ctw_out_if.source                  out_ch
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_XW = ROW_W + 1;
    localparam int COL_XW = COL_W + 1;

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_RDWAIT = 6'b001000,
        S_FILL   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [ctw_pkg::ATTR_W-1:0]   attr_reg;
    logic [COL_W-1:0]             col_reg, col_next;
    logic [ROW_W-1:0]             row_reg, row_next;
    logic [ROW_W-1:0]             top_reg, top_next;
    logic [ADDR_W-1:0]            fill_addr_reg, fill_addr_next;
    logic [ADDR_W-1:0]            fill_last_reg, fill_last_next;
    logic                         out_valid_reg, out_valid_next;
    logic [ctw_pkg::OFFSET_W-1:0] out_offset_reg, out_offset_next;
    logic [ctw_pkg::CELL_W-1:0]   out_word_reg, out_word_next;
    logic [ctw_pkg::CELL_W-1:0]   word_reg, word_next;

    logic [ctw_pkg::MODE_W-1:0]   mode_reg;
    logic [ctw_pkg::CHAR_W-1:0]   code_reg;
    logic [ctw_pkg::RROW_W-1:0]   rrow_reg;
    logic [ctw_pkg::RCOL_W-1:0]   rcol_reg;

    logic                         in_accept;
    logic                         out_load;
    logic                         read_ok;
    logic                         is_print;
    logic                         scroll;
    logic [COL_XW-1:0]            col_n;
    logic [ROW_XW-1:0]            row_n;
    logic [ROW_W-1:0]             acc_row;
    logic [COL_W-1:0]             acc_col;
    logic [ADDR_W-1:0]            acc_addr;
    logic [ADDR_W-1:0]            top_base;
    logic [ROW_W-1:0]             top_inc;

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [ctw_pkg::CELL_W-1:0]   ram_wdata;
    logic                         ram_re;
    logic [ctw_pkg::CELL_W-1:0]   ram_rdata;

    // Map a logical row/column to a memory address through the top-row pointer.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] top,
        input logic [ROW_W-1:0] lrow,
        input logic [COL_W-1:0] col
    );
        logic [ROW_XW-1:0] prow;
        prow = {1'b0, top} + {1'b0, lrow};
        if (prow >= ROW_XW'(ROWS))
        begin
            prow = prow - ROW_XW'(ROWS);
        end
        return ADDR_W'(prow * COLUMNS) + ADDR_W'(col);
    endfunction

    ctw_ram #(
        .WIDTH (ctw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (acc_addr),
        .rdata (ram_rdata)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.cursor_offset = out_offset_reg;
    assign out_ch.cell_word     = out_word_reg;

    assign read_ok = (32'(rrow_reg) < 32'(ROWS)) && (32'(rcol_reg) < 32'(COLUMNS));

    assign acc_row  = (mode_reg == ctw_pkg::MODE_READ) ? ROW_W'(rrow_reg) : row_reg;
    assign acc_col  = (mode_reg == ctw_pkg::MODE_READ) ? COL_W'(rcol_reg) : col_reg;
    assign acc_addr = cell_addr(top_reg, acc_row, acc_col);
    assign top_base = ADDR_W'(top_reg * COLUMNS);
    assign top_inc  = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + ROW_W'(1);

    // Cursor update for put mode
    always_comb
    begin
        col_n    = {1'b0, col_reg};
        row_n    = {1'b0, row_reg};
        is_print = 1'b0;
        priority if (code_reg == ctw_pkg::CODE_BS)
        begin
            if (col_reg != '0)
            begin
                col_n = col_n - COL_XW'(1);
            end
        end
        else if (code_reg == ctw_pkg::CODE_TAB)
        begin
            col_n = (col_n + COL_XW'(8)) & ~COL_XW'(7);
        end
        else if (code_reg == ctw_pkg::CODE_CR)
        begin
            col_n = '0;
        end
        else if (code_reg == ctw_pkg::CODE_LF)
        begin
            col_n = '0;
            row_n = row_n + ROW_XW'(1);
        end
        else if (code_reg >= ctw_pkg::CODE_PRINT_LO && code_reg <= ctw_pkg::CODE_PRINT_HI)
        begin
            is_print = 1'b1;
            col_n    = col_n + COL_XW'(1);
        end
        else
        begin
            is_print = 1'b0;
        end
        // wrap at the right edge
        if (32'(col_n) >= 32'(COLUMNS))
        begin
            col_n = '0;
            row_n = row_n + ROW_XW'(1);
        end
        scroll = (32'(row_n) >= 32'(ROWS));
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        top_next        = top_reg;
        fill_addr_next  = fill_addr_reg;
        fill_last_next  = fill_last_reg;
        word_next       = word_reg;
        out_valid_next  = out_valid_reg;
        out_offset_next = out_offset_reg;
        out_word_next   = out_word_reg;
        ram_we          = 1'b0;
        ram_waddr       = fill_addr_reg;
        ram_wdata       = {attr_reg, ctw_pkg::BLANK_CHAR};
        ram_re          = 1'b0;

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                ram_we         = 1'b1;
                ram_wdata      = ctw_pkg::CELL_RESET;
                fill_addr_next = fill_addr_reg + ADDR_W'(1);
                if (fill_addr_reg == fill_last_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                word_next  = '0;
                state_next = S_DONE;
                unique case (mode_reg)
                    ctw_pkg::MODE_PUT:
                    begin
                        ram_we    = is_print;
                        ram_waddr = acc_addr;
                        ram_wdata = {attr_reg, code_reg};
                        col_next  = COL_W'(col_n);
                        if (scroll)
                        begin
                            // blank the old top row, which becomes the bottom row
                            row_next       = ROW_W'(ROWS - 1);
                            top_next       = top_inc;
                            fill_addr_next = top_base;
                            fill_last_next = top_base + ADDR_W'(COLUMNS - 1);
                            state_next     = S_FILL;
                        end
                        else
                        begin
                            row_next = ROW_W'(row_n);
                        end
                    end
                    ctw_pkg::MODE_CLEAR:
                    begin
                        col_next       = '0;
                        row_next       = '0;
                        top_next       = '0;
                        fill_addr_next = '0;
                        fill_last_next = ADDR_W'(CELLS - 1);
                        state_next     = S_FILL;
                    end
                    ctw_pkg::MODE_READ:
                    begin
                        if (read_ok)
                        begin
                            ram_re     = 1'b1;
                            state_next = S_RDWAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RDWAIT:
            begin
                word_next  = ram_rdata;
                state_next = S_DONE;
            end
            S_FILL:
            begin
                ram_we         = 1'b1;
                fill_addr_next = fill_addr_reg + ADDR_W'(1);
                if (fill_addr_reg == fill_last_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_offset_next = ctw_pkg::OFFSET_W'(row_reg * COLUMNS + 32'(col_reg));
                    out_word_next   = word_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            attr_reg      <= ctw_pkg::ATTR_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            top_reg       <= '0;
            fill_addr_reg <= '0;
            fill_last_reg <= ADDR_W'(CELLS - 1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            top_reg       <= top_next;
            fill_addr_reg <= fill_addr_next;
            fill_last_reg <= fill_last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg <= in_ch.mode;
            code_reg <= in_ch.char_code;
            rrow_reg <= in_ch.read_row;
            rcol_reg <= in_ch.read_col;
        end
        word_reg       <= word_next;
        out_offset_reg <= out_offset_next;
        out_word_reg   <= out_word_next;
    end

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < 32'(COLUMNS)) && (32'(row_reg) < 32'(ROWS)) && (32'(top_reg) < 32'(ROWS)))
        else $error("cursor or top row out of range");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(ram_waddr) < 32'(CELLS)))
        else $error("cell write beyond memory");

    a_read_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (state_reg == S_RDWAIT))
        else $error("read data not captured after read");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=>
            (out_valid_reg && $stable(out_offset_reg) && $stable(out_word_reg)))
        else $error("pending result overwritten");

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL || state_reg == S_INIT) |-> !in_ch.ready)
        else $error("word accepted during memory sweep");

endmodule
